// ===== rtl/at_command_line_parser_unit_defines.svh =====
// Assertion macros shared by the parser checker.
`ifndef AT_COMMAND_LINE_PARSER_UNIT_DEFINES_SVH
`define AT_COMMAND_LINE_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ATCLP_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("parser check failed: same-cycle rule");

// Next-cycle implication, checked outside reset.
`define ATCLP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("parser check failed: next-cycle rule");

`endif

// ===== rtl/atclp_pkg.sv =====
// Types, constants and helper functions of the AT command line parser.
`timescale 1ns / 1ps
`default_nettype none
package atclp_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      MODE_A,
      MODE_T,
      MODE_TYPE,
      MODE_ARG
   } mode_type;

   typedef enum logic [2:0] {
      MSG_NONE,
      MSG_BS,
      MSG_OK,
      MSG_ERR,
      MSG_DISP
   } msg_type;

   typedef enum logic [1:0] {
      SC_START,
      SC_FIELD,
      SC_QUOTE
   } scan_type;

   localparam logic [1:0] CK_EXEC = 2'd0;
   localparam logic [1:0] CK_SET  = 2'd1;
   localparam logic [1:0] CK_READ = 2'd2;
   localparam logic [1:0] CK_TEST = 2'd3;

   localparam logic [2:0] REG_ECHO  = 3'd0;
   localparam logic [2:0] REG_NAME0 = 3'd1;
   localparam logic [2:0] REG_NAME1 = 3'd2;
   localparam logic [2:0] REG_NAME2 = 3'd3;
   localparam logic [2:0] REG_NAME3 = 3'd4;
   localparam logic [2:0] REG_SLOTS = 3'd5;

   localparam logic [7:0] CH_DEL   = 8'h7f;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_QUERY = 8'h3f;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_NUL   = 8'h00;

   // Built-in names, byte 0 in the low bits, NUL padded.
   localparam logic [63:0] NAME_E  = 64'h0000_0000_0000_0045;
   localparam logic [63:0] NAME_E0 = 64'h0000_0000_0000_3045;
   localparam logic [63:0] NAME_E1 = 64'h0000_0000_0000_3145;

   typedef struct packed {
      logic    accept;
      logic    commit;
      logic    scan_start;
      logic    scan_eval;
      logic    load;
      logic    sel_echo;
      logic [2:0] pos;
      logic    last;
   } ctl_word_type;

   typedef struct packed {
      logic    need_scan;
      logic    scan_done;
      logic    echo_emit;
      msg_type msg;
      msg_type plan_msg;
      logic    out_free;
   } status_type;

   function automatic logic [2:0] msg_len(input msg_type m);
      logic [2:0] n;
      unique case (m)
         MSG_BS:   n = 3'd3;
         MSG_OK:   n = 3'd4;
         MSG_ERR:  n = 3'd7;
         MSG_DISP: n = 3'd1;
         default:  n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] msg_byte(input msg_type m, input logic [2:0] pos);
      logic [7:0] b;
      b = CH_NUL;
      unique case (m)
         MSG_BS: begin
            b = (pos == 3'd1) ? CH_SPACE : CH_BS;
         end
         MSG_OK: begin
            case (pos)
               3'd0:    b = 8'h4f;
               3'd1:    b = 8'h4b;
               3'd2:    b = CH_CR;
               default: b = CH_LF;
            endcase
         end
         MSG_ERR: begin
            case (pos)
               3'd0:    b = 8'h45;
               3'd1:    b = 8'h52;
               3'd2:    b = 8'h52;
               3'd3:    b = 8'h4f;
               3'd4:    b = 8'h52;
               3'd5:    b = CH_CR;
               default: b = CH_LF;
            endcase
         end
         default: b = CH_NUL;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] fold(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/at_command_line_parser_unit.sv =====
// Top level of the AT command line parser.
//
// channel  direction  handshake              payload
// req      in         req_valid / req_stall  opcode, rx_byte, resp_error
// rsp      out        rsp_valid / rsp_stall  kind, tx_byte, cmd_slot, cmd_kind, param_count, last
// csr      in         csr_valid / csr_ready  csr_index, csr_wdata (always ready)
//
// A transaction is accepted, then decided; a SET line also scans its argument bytes with a read
// state and an evaluate state per byte (the argument RAM read is registered), then emits its results.
// Results leave through one output register; the next request is taken once the
// last result is loaded, even if that result is still stalled.
// Synchronous active-high reset; no clearing pass, buffers are read below their lengths.
`timescale 1ns / 1ps
`default_nettype none
module at_command_line_parser_unit #(
   parameter int NAME_BYTES = 8,
   parameter int ARG_BYTES  = 64,
   parameter int MAX_PARAMS = 8,
   parameter int NAME_SLOTS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_opcode,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_resp_error,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [7:0]       rsp_tx_byte,
   output logic [1:0]       rsp_cmd_slot,
   output logic [1:0]       rsp_cmd_kind,
   output logic [3:0]       rsp_param_count,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);
   import atclp_pkg::*;

   ctl_word_type cmd;
   status_type   st;

   assign csr_ready = 1'b1;

   atclp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   atclp_datapath #(
      .NAME_BYTES (NAME_BYTES),
      .ARG_BYTES  (ARG_BYTES),
      .MAX_PARAMS (MAX_PARAMS),
      .NAME_SLOTS (NAME_SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_opcode      (req_opcode),
      .req_rx_byte     (req_rx_byte),
      .req_resp_error  (req_resp_error),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_cmd_slot    (rsp_cmd_slot),
      .rsp_cmd_kind    (rsp_cmd_kind),
      .rsp_param_count (rsp_param_count),
      .rsp_last        (rsp_last)
   );
endmodule
`default_nettype wire

// ===== rtl/atclp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module atclp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/atclp_datapath.sv =====
// Parser datapath: line state, name match, argument buffer, parameter scan, result register.
`timescale 1ns / 1ps
`default_nettype none
module atclp_datapath #(
   parameter int NAME_BYTES = 8,
   parameter int ARG_BYTES  = 64,
   parameter int MAX_PARAMS = 8,
   parameter int NAME_SLOTS = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire atclp_pkg::ctl_word_type cmd,
   output atclp_pkg::status_type        st,
   input  wire logic                    req_opcode,
   input  wire logic [7:0]              req_rx_byte,
   input  wire logic                    req_resp_error,
   input  wire logic                    csr_valid,
   input  wire logic [2:0]              csr_index,
   input  wire logic [63:0]             csr_wdata,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic                         rsp_kind,
   output logic [7:0]                   rsp_tx_byte,
   output logic [1:0]                   rsp_cmd_slot,
   output logic [1:0]                   rsp_cmd_kind,
   output logic [3:0]                   rsp_param_count,
   output logic                         rsp_last
);
   import atclp_pkg::*;

   localparam int NW = $clog2(NAME_BYTES);
   localparam int AW = $clog2(ARG_BYTES);
   localparam int CW = $clog2(MAX_PARAMS + 1);

   // input transaction
   logic        in_op_ff, in_err_ff;
   logic [7:0]  in_byte_ff;

   // configuration
   logic        echo_init_ff;
   logic [63:0] word_ff [4];
   logic [2:0]  slots_ff;

   // line state
   mode_type        mode_ff, mode_in;
   logic [1:0]      pend_ff, pend_in;
   logic            ts_ff, ts_in;
   logic [7:0]      name_ff [NAME_BYTES];
   logic [NW-1:0]   name_len_ff, name_len_in;
   logic [AW-1:0]   arg_len_ff, arg_len_in;
   logic [7:0]      arg0_ff;
   logic            echo_ff, echo_in;
   logic            await_ff, await_in;
   logic            name_we, arg_we;

   // parameter scan
   logic [AW-1:0]   sidx_ff;
   scan_type        sst_ff;
   logic [CW-1:0]   scnt_ff;
   logic            ssat_ff, sdone_ff;
   logic [7:0]      rd_data;
   logic [CW-1:0]   cnt_final;
   logic            unterm;

   // plan
   msg_type         d_msg, plan_ff;
   logic            d_echo;
   logic [1:0]      d_ck, slot_ff, ck_ff;
   logic [CW-1:0]   d_cnt, cnt_ff;

   // name search
   logic            m_e, m_e0, m_e1, hit;
   logic [1:0]      hit_slot;
   logic [2:0]      slots_lim;

   logic            do_run;
   logic [1:0]      run_ck;
   logic [CW-1:0]   run_cnt;
   logic            is_eol;

   function automatic logic match_name(input logic [63:0] cand,
                                       input logic [NW-1:0] len);
      logic       ok;
      logic       ended;
      logic [7:0] a;
      ok = 1'b1;
      ended = 1'b0;
      for (int i = 0; i < NAME_BYTES; i++) begin
         a = (NW'(i) < len) ? name_ff[i] : CH_NUL;
         if (!ended && fold(a) != fold(cand[8*i +: 8])) begin
            ok = 1'b0;
         end
         if (a == CH_NUL) begin
            ended = 1'b1;
         end
      end
      return ok;
   endfunction

   atclp_ram #(.WIDTH(8), .DEPTH(ARG_BYTES)) u_arg_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && arg_we),
      .wr_addr (arg_len_ff),
      .wr_data (in_byte_ff),
      .rd_addr (sidx_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      slots_lim = (slots_ff > 3'(NAME_SLOTS)) ? 3'(NAME_SLOTS) : slots_ff;
      m_e  = match_name(NAME_E, name_len_ff);
      m_e0 = match_name(NAME_E0, name_len_ff);
      m_e1 = match_name(NAME_E1, name_len_ff);
      hit = 1'b0;
      hit_slot = 2'd0;
      for (int s = NAME_SLOTS - 1; s >= 0; s--) begin
         if (!hit && 3'(s) < slots_lim && match_name(word_ff[s], name_len_ff)) begin
            hit = 1'b1;
            hit_slot = 2'(s);
         end
      end
   end

   always_comb begin
      cnt_final = ssat_ff ? scnt_ff : ((sst_ff == SC_FIELD) ? scnt_ff + CW'(1) : scnt_ff);
      unterm    = !ssat_ff && sst_ff == SC_QUOTE;
   end

   assign is_eol = (in_byte_ff == CH_CR) || (in_byte_ff == CH_LF);

   // What this transaction does, from the state before it
   always_comb begin
      d_echo      = 1'b0;
      d_msg       = MSG_NONE;
      d_ck        = CK_EXEC;
      d_cnt       = '0;
      mode_in     = mode_ff;
      pend_in     = pend_ff;
      ts_in       = ts_ff;
      name_len_in = name_len_ff;
      arg_len_in  = arg_len_ff;
      echo_in     = echo_ff;
      await_in    = await_ff;
      name_we     = 1'b0;
      arg_we      = 1'b0;
      do_run      = 1'b0;
      run_ck      = CK_EXEC;
      run_cnt     = '0;
      st.need_scan = 1'b0;
      if (in_op_ff) begin
         if (await_ff) begin
            d_msg    = in_err_ff ? MSG_ERR : MSG_OK;
            await_in = 1'b0;
         end
      end else if (await_ff) begin
         // bytes dropped until software answers
      end else if (in_byte_ff == CH_DEL) begin
         if (mode_ff != MODE_A) begin
            unique case (mode_ff)
               MODE_T: mode_in = MODE_A;
               MODE_TYPE: begin
                  if (name_len_ff != '0) name_len_in = name_len_ff - NW'(1);
                  else mode_in = MODE_T;
               end
               default: begin
                  if (arg_len_ff != '0) arg_len_in = arg_len_ff - AW'(1);
                  else mode_in = MODE_TYPE;
               end
            endcase
            if (echo_ff) d_msg = MSG_BS;
         end
      end else if (mode_ff == MODE_A) begin
         if (fold(in_byte_ff) == 8'h41) begin
            mode_in = MODE_T;
            d_echo  = echo_ff;
         end
      end else if (mode_ff == MODE_T) begin
         if (fold(in_byte_ff) == 8'h54) begin
            mode_in = MODE_TYPE;
            d_echo  = echo_ff;
         end else begin
            mode_in = MODE_A;
         end
      end else if (mode_ff == MODE_TYPE) begin
         d_echo = echo_ff;
         if (is_eol) begin
            if (name_len_ff == '0) begin
               d_msg = MSG_OK;
            end else begin
               do_run = 1'b1;
               run_ck = ts_ff ? pend_ff : CK_EXEC;
            end
         end else if (in_byte_ff == CH_EQ || in_byte_ff == CH_QUERY) begin
            pend_in = (in_byte_ff == CH_EQ) ? CK_SET : CK_READ;
            ts_in   = 1'b1;
            mode_in = MODE_ARG;
         end else if (name_len_ff < NW'(NAME_BYTES - 1)) begin
            name_we     = 1'b1;
            name_len_in = name_len_ff + NW'(1);
         end
      end else begin
         d_echo = echo_ff;
         if (is_eol) begin
            if (pend_ff == CK_SET) begin
               if (arg_len_ff == AW'(1) && arg0_ff == CH_QUERY) begin
                  do_run = 1'b1;
                  run_ck = CK_TEST;
               end else begin
                  st.need_scan = 1'b1;
                  if (unterm) begin
                     d_msg = MSG_ERR;
                  end else begin
                     do_run  = 1'b1;
                     run_ck  = CK_SET;
                     run_cnt = cnt_final;
                  end
               end
            end else if (arg_len_ff != '0) begin
               d_msg = MSG_ERR;
            end else begin
               do_run = 1'b1;
               run_ck = CK_READ;
            end
         end else if (arg_len_ff < AW'(ARG_BYTES - 1)) begin
            arg_we     = 1'b1;
            arg_len_in = arg_len_ff + AW'(1);
         end
      end
      if (is_eol && !in_op_ff && !await_ff &&
          (mode_ff == MODE_TYPE || mode_ff == MODE_ARG)) begin
         mode_in     = MODE_A;
         name_len_in = '0;
         arg_len_in  = '0;
         pend_in     = CK_EXEC;
         ts_in       = 1'b0;
      end
      if (do_run) begin
         if (m_e || (!hit && (m_e1 || m_e0))) begin
            if (run_ck != CK_EXEC) begin
               d_msg = MSG_ERR;
            end else begin
               echo_in = m_e1;
               d_msg   = MSG_OK;
            end
         end else if (hit) begin
            d_msg    = MSG_DISP;
            d_ck     = run_ck;
            d_cnt    = run_cnt;
            await_in = 1'b1;
         end else begin
            d_msg = MSG_ERR;
         end
      end
      st.echo_emit = d_echo;
      st.msg       = d_msg;
      st.plan_msg  = plan_ff;
      st.scan_done = sdone_ff;
      st.out_free  = !rsp_valid || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         in_op_ff   <= req_opcode;
         in_byte_ff <= req_rx_byte;
         in_err_ff  <= req_resp_error;
      end
      if (cmd.commit && name_we) begin
         name_ff[name_len_ff] <= in_byte_ff;
      end
      if (cmd.commit && arg_we && arg_len_ff == '0) begin
         arg0_ff <= in_byte_ff;
      end
      if (cmd.commit) begin
         plan_ff <= d_msg;
         slot_ff <= hit_slot;
         ck_ff   <= d_ck;
         cnt_ff  <= d_cnt;
      end
      if (cmd.load) begin
         if (cmd.sel_echo) begin
            rsp_kind    <= 1'b0;
            rsp_tx_byte <= in_byte_ff;
         end else begin
            rsp_kind    <= (plan_ff == MSG_DISP);
            rsp_tx_byte <= msg_byte(plan_ff, cmd.pos);
         end
         rsp_cmd_slot    <= (!cmd.sel_echo && plan_ff == MSG_DISP) ? slot_ff : 2'd0;
         rsp_cmd_kind    <= (!cmd.sel_echo && plan_ff == MSG_DISP) ? ck_ff : CK_EXEC;
         rsp_param_count <= (!cmd.sel_echo && plan_ff == MSG_DISP) ? 4'(cnt_ff) : 4'd0;
         rsp_last        <= cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_A;
         pend_ff      <= CK_EXEC;
         ts_ff        <= 1'b0;
         name_len_ff  <= '0;
         arg_len_ff   <= '0;
         echo_ff      <= 1'b0;
         echo_init_ff <= 1'b0;
         await_ff     <= 1'b0;
         slots_ff     <= 3'd0;
         for (int i = 0; i < 4; i++) word_ff[i] <= '0;
         rsp_valid    <= 1'b0;
         sidx_ff      <= '0;
         sst_ff       <= SC_START;
         scnt_ff      <= '0;
         ssat_ff      <= 1'b0;
         sdone_ff     <= 1'b0;
      end else begin
         if (cmd.commit) begin
            mode_ff     <= mode_in;
            pend_ff     <= pend_in;
            ts_ff       <= ts_in;
            name_len_ff <= name_len_in;
            arg_len_ff  <= arg_len_in;
            echo_ff     <= echo_in;
            await_ff    <= await_in;
         end
         if (csr_valid && csr_index == REG_ECHO) begin
            echo_init_ff <= csr_wdata[0];
            echo_ff      <= csr_wdata[0];
         end else if (reset) begin
            echo_ff <= echo_init_ff;
         end
         if (csr_valid && csr_index == REG_SLOTS) begin
            slots_ff <= csr_wdata[2:0];
         end
         if (csr_valid) begin
            unique case (csr_index)
               REG_NAME0: word_ff[0] <= csr_wdata;
               REG_NAME1: word_ff[1] <= csr_wdata;
               REG_NAME2: word_ff[2] <= csr_wdata;
               REG_NAME3: word_ff[3] <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.load) rsp_valid <= 1'b1;
         else if (!rsp_stall) rsp_valid <= 1'b0;
         if (cmd.scan_start) begin
            sidx_ff  <= '0;
            sst_ff   <= SC_START;
            scnt_ff  <= '0;
            ssat_ff  <= 1'b0;
            sdone_ff <= (arg_len_ff == '0);
         end else if (cmd.scan_eval) begin
            if (rd_data == CH_NUL) begin
               sdone_ff <= 1'b1;
            end else begin
               if (({1'b0, sidx_ff} + (AW+1)'(1)) >= {1'b0, arg_len_ff}) sdone_ff <= 1'b1;
               sidx_ff <= sidx_ff + AW'(1);
               unique case (sst_ff)
                  SC_START: begin
                     if (rd_data == CH_COMMA) begin
                        scnt_ff <= scnt_ff + CW'(1);
                        if (scnt_ff + CW'(1) == CW'(MAX_PARAMS)) begin
                           ssat_ff  <= 1'b1;
                           sdone_ff <= 1'b1;
                        end
                     end else if (rd_data == CH_QUOTE) begin
                        sst_ff <= SC_QUOTE;
                     end else begin
                        sst_ff <= SC_FIELD;
                     end
                  end
                  SC_FIELD: begin
                     if (rd_data == CH_COMMA) begin
                        scnt_ff <= scnt_ff + CW'(1);
                        sst_ff  <= SC_START;
                        if (scnt_ff + CW'(1) == CW'(MAX_PARAMS)) begin
                           ssat_ff  <= 1'b1;
                           sdone_ff <= 1'b1;
                        end
                     end
                  end
                  default: begin
                     if (rd_data == CH_QUOTE) sst_ff <= SC_FIELD;
                  end
               endcase
            end
         end
      end
   end
endmodule
`default_nettype wire

// ===== rtl/atclp_ctrl.sv =====
// Parser controller: transaction intake, scan sequencing and result emission.
`timescale 1ns / 1ps
`default_nettype none
module atclp_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire atclp_pkg::status_type  st,
   output atclp_pkg::ctl_word_type     cmd
);
   import atclp_pkg::*;

   state_type  state_ff, state_in;
   logic       echo_left_ff, echo_left_in;
   logic [2:0] pos_ff, pos_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         echo_left_ff <= 1'b0;
         pos_ff       <= 3'd0;
      end else begin
         state_ff     <= state_in;
         echo_left_ff <= echo_left_in;
         pos_ff       <= pos_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      echo_left_in = echo_left_ff;
      pos_in       = pos_ff;
      cmd          = '0;
      req_stall    = (state_ff != ST_IDLE);
      unique case (state_ff) inside
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECIDE;
            end
         end
         ST_DECIDE, ST_SCAN_RD: begin
            if (state_ff == ST_DECIDE && st.need_scan) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN_RD;
            end else if (state_ff == ST_SCAN_RD && !st.scan_done) begin
               state_in = ST_SCAN_EV;
            end else begin
               cmd.commit   = 1'b1;
               echo_left_in = st.echo_emit;
               pos_in       = 3'd0;
               state_in     = (st.echo_emit || st.msg != MSG_NONE) ? ST_EMIT : ST_IDLE;
            end
         end
         ST_SCAN_EV: begin
            // read data for the current index is valid here
            cmd.scan_eval = 1'b1;
            state_in      = ST_SCAN_RD;
         end
         ST_EMIT: begin
            if (st.out_free) begin
               cmd.load = 1'b1;
               if (echo_left_ff) begin
                  cmd.sel_echo = 1'b1;
                  cmd.last     = (st.plan_msg == MSG_NONE);
                  echo_left_in = 1'b0;
               end else begin
                  cmd.pos  = pos_ff;
                  cmd.last = (pos_ff == msg_len(st.plan_msg) - 3'd1);
                  pos_in   = pos_ff + 3'd1;
               end
               if (cmd.last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/atclp_checker.sv =====
// Port-level checker for the AT command line parser and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "at_command_line_parser_unit_defines.svh"
module atclp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_kind,
   input wire logic [7:0]  rsp_tx_byte,
   input wire logic [1:0]  rsp_cmd_slot,
   input wire logic [1:0]  rsp_cmd_kind,
   input wire logic [3:0]  rsp_param_count,
   input wire logic        rsp_last
);
   `ATCLP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_tx_byte))
   `ATCLP_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)
   `ATCLP_ASSERT_IMPL(a_disp_last, rsp_valid && rsp_kind, rsp_last && rsp_tx_byte == 8'd0)
   `ATCLP_ASSERT_IMPL(a_tx_clean, rsp_valid && !rsp_kind, rsp_cmd_slot == 2'd0 && rsp_cmd_kind == 2'd0 && rsp_param_count == 4'd0)
endmodule

bind at_command_line_parser_unit atclp_checker u_chk (.*);
`default_nettype wire
